### sv/bfa_pkg.sv
// Shared constants, codes and structs for the best-fit heap allocator.
// Depends on nothing; every other file but bfa_ram refers to it by scoped names.
package bfa_pkg;

  localparam int ARENA_BYTES   = 8192;
  localparam int HEADER_BYTES  = 16;
  localparam int MAX_FREE_SEGS = 64;
  localparam int MAX_ALLOCS    = 64;

  localparam int OFFW  = $clog2(ARENA_BYTES);
  localparam int SUMW  = OFFW + 1;
  localparam int REQW  = 14;
  localparam int IDW   = 16;
  localparam int STW   = 3;
  localparam int DOFFW = 13;
  localparam int CMPW  = ((OFFW > REQW) ? OFFW : REQW) + 1;
  localparam int FIDXW = $clog2(MAX_FREE_SEGS);
  localparam int AIDXW = $clog2(MAX_ALLOCS);
  localparam int FCW   = $clog2(MAX_FREE_SEGS + 1);
  localparam int MAXN  = (MAX_FREE_SEGS > MAX_ALLOCS) ? MAX_FREE_SEGS : MAX_ALLOCS;
  localparam int CNTW  = $clog2(MAXN + 1);
  localparam int FSEGW = 2 * OFFW;
  localparam int ARECW = IDW + 2 * OFFW;

  localparam logic [OFFW-1:0] HDR       = OFFW'(HEADER_BYTES);
  localparam logic [OFFW-1:0] INIT_SIZE = OFFW'(ARENA_BYTES - HEADER_BYTES);

  typedef enum logic [STW-1:0] {
    ST_WHOLE   = 3'd0,
    ST_SPLIT   = 3'd1,
    ST_BADSIZE = 3'd2,
    ST_NOMEM   = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_FREED   = 3'd5
  } status_e;

  typedef struct packed {
    logic [OFFW-1:0] start;
    logic [OFFW-1:0] size;
  } fseg_t;

  typedef struct packed {
    logic [IDW-1:0]  ident;
    logic [OFFW-1:0] dat;
    logic [OFFW-1:0] len;
  } arec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic load;
    logic ascan;
    logic aupd;
    logic fscan;
    logic pscan;
    logic fupd;
    logic shdn;
    logic shup;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alloc;
    logic early;
    logic done;
    logic found;
    logic whole;
    logic both;
    logic one;
    logic full;
  } sts_t;

endpackage

### sv/bfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/bfa_ctrl.sv
// Sequencer of the allocator: one-hot state machine that issues commands.
// Depends on bfa_pkg (cmd_t, sts_t).
module bfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bfa_pkg::sts_t sts_i,
  output bfa_pkg::cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_ASCAN = 10'b00_0000_0100,
    S_AUPD  = 10'b00_0000_1000,
    S_FSCAN = 10'b00_0001_0000,
    S_PSCAN = 10'b00_0010_0000,
    S_FUPD  = 10'b00_0100_0000,
    S_SHDN  = 10'b00_1000_0000,
    S_SHUP  = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:  state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          if (sts_i.early)      state_d = S_FIN;
          else if (sts_i.alloc) state_d = S_ASCAN;
          else                  state_d = S_FSCAN;
        end
      end
      S_ASCAN: if (sts_i.done) state_d = S_AUPD;
      S_AUPD:  state_d = (sts_i.found && sts_i.whole) ? S_SHDN : S_FIN;
      S_FSCAN: if (sts_i.done) state_d = sts_i.found ? S_PSCAN : S_FIN;
      S_PSCAN: if (sts_i.done) state_d = S_FUPD;
      S_FUPD: begin
        if (sts_i.both)                    state_d = S_SHDN;
        else if (sts_i.one || sts_i.full)  state_d = S_FIN;
        else                               state_d = S_SHUP;
      end
      S_SHDN:  if (sts_i.done) state_d = S_FIN;
      S_SHUP:  if (sts_i.done) state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.init  = (state_q == S_INIT);
    cmd_o.load  = (state_q == S_IDLE) && start_i;
    cmd_o.ascan = (state_q == S_ASCAN);
    cmd_o.aupd  = (state_q == S_AUPD);
    cmd_o.fscan = (state_q == S_FSCAN);
    cmd_o.pscan = (state_q == S_PSCAN);
    cmd_o.fupd  = (state_q == S_FUPD);
    cmd_o.shdn  = (state_q == S_SHDN);
    cmd_o.shup  = (state_q == S_SHUP);
    cmd_o.fin   = (state_q == S_FIN);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but controller not busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.fin |=> !busy_o)
    else $error("controller did not return to idle after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.init |=> !cmd_o.init)
    else $error("init seeding repeated");

endmodule

### sv/bfa_dp.sv
// Datapath of the allocator: free-segment table, allocation table, scan logic.
// Depends on bfa_pkg and bfa_ram.
module bfa_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfa_pkg::cmd_t                cmd_i,
  output bfa_pkg::sts_t                sts_o,
  input  logic                         action_i,
  input  logic [bfa_pkg::REQW-1:0]     request_size_i,
  input  logic [bfa_pkg::IDW-1:0]      block_id_i,
  output logic [bfa_pkg::STW-1:0]      status_o,
  output logic [bfa_pkg::DOFFW-1:0]    data_offset_o,
  output logic [bfa_pkg::IDW-1:0]      assigned_id_o,
  output logic                         done_o
);

  // control state
  logic [bfa_pkg::FCW-1:0]        fcount_q, fcount_d;
  logic [bfa_pkg::IDW-1:0]        next_id_q, next_id_d;
  logic [bfa_pkg::MAX_ALLOCS-1:0] valid_q, valid_d;
  logic [bfa_pkg::CNTW-1:0]       cnt_q, cnt_d;
  logic [bfa_pkg::CNTW-1:0]       rix_q, rix_d;
  logic                           rv_q, rv_d;
  logic                           found_q, found_d;
  logic                           hl_q, hl_d, hr_q, hr_d;

  // payload
  logic [bfa_pkg::REQW-1:0]  req_q, req_d;
  logic [bfa_pkg::IDW-1:0]   id_q, id_d;
  logic [bfa_pkg::CNTW-1:0]  best_q, best_d;
  logic [bfa_pkg::OFFW-1:0]  bsize_q, bsize_d, bstart_q, bstart_d;
  logic [bfa_pkg::AIDXW-1:0] slot_q, slot_d;
  logic [bfa_pkg::OFFW-1:0]  bdat_q, bdat_d, blen_q, blen_d;
  logic [bfa_pkg::CNTW-1:0]  pos_q, pos_d;
  bfa_pkg::fseg_t            lft_q, lft_d, rgt_q, rgt_d;
  logic [bfa_pkg::STW-1:0]   rst_q, rst_d;
  logic [bfa_pkg::OFFW-1:0]  roff_q, roff_d;
  logic [bfa_pkg::IDW-1:0]   rid_q, rid_d;

  // memories
  logic                       fw_we;
  logic [bfa_pkg::FIDXW-1:0]  fw_addr, fr_addr;
  logic [bfa_pkg::FSEGW-1:0]  fw_data, fr_rdata;
  logic                       aw_we;
  logic [bfa_pkg::ARECW-1:0]  aw_data, ar_rdata;
  logic [bfa_pkg::AIDXW-1:0]  ar_addr;

  bfa_ram #(.Width(bfa_pkg::FSEGW), .Depth(bfa_pkg::MAX_FREE_SEGS)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (fw_we),
    .waddr_i(fw_addr),
    .wdata_i(fw_data),
    .raddr_i(fr_addr),
    .rdata_o(fr_rdata)
  );

  bfa_ram #(.Width(bfa_pkg::ARECW), .Depth(bfa_pkg::MAX_ALLOCS)) u_alloc_ram (
    .clk_i  (clk_i),
    .we_i   (aw_we),
    .waddr_i(slot_q),
    .wdata_i(aw_data),
    .raddr_i(ar_addr),
    .rdata_o(ar_rdata)
  );

  // first free allocation slot
  logic                      free_any;
  logic [bfa_pkg::AIDXW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = bfa_pkg::MAX_ALLOCS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = bfa_pkg::AIDXW'(i);
      end
    end
  end

  // helpers
  bfa_pkg::fseg_t            fr_seg;
  bfa_pkg::arec_t            ar_rec;
  logic [bfa_pkg::CNTW-1:0]  fcnt_ext, cnt_inc, cnt_dec, rix_dec, rix_inc, pos_dec, pos_inc;
  logic [bfa_pkg::CMPW-1:0]  req_c;
  logic [bfa_pkg::OFFW-1:0]  bs, dat_a;
  logic [bfa_pkg::SUMW-1:0]  lsum, rsum;
  logic                      whole, left, right, full;
  logic [bfa_pkg::IDW-1:0]   nid;

  assign fr_seg   = bfa_pkg::fseg_t'(fr_rdata);
  assign ar_rec   = bfa_pkg::arec_t'(ar_rdata);
  assign fcnt_ext = bfa_pkg::CNTW'(fcount_q);
  assign cnt_inc  = cnt_q + bfa_pkg::CNTW'(1);
  assign cnt_dec  = cnt_q - bfa_pkg::CNTW'(1);
  assign rix_dec  = rix_q - bfa_pkg::CNTW'(1);
  assign rix_inc  = rix_q + bfa_pkg::CNTW'(1);
  assign pos_dec  = pos_q - bfa_pkg::CNTW'(1);
  assign pos_inc  = pos_q + bfa_pkg::CNTW'(1);
  assign req_c    = bfa_pkg::CMPW'(req_q);
  assign bs       = bdat_q - bfa_pkg::HDR;
  assign dat_a    = bstart_q + bfa_pkg::HDR;
  assign whole    = bfa_pkg::CMPW'(bsize_q) <= (req_c + bfa_pkg::CMPW'(bfa_pkg::HEADER_BYTES));
  assign lsum     = bfa_pkg::SUMW'(lft_q.start) + bfa_pkg::SUMW'(bfa_pkg::HDR)
                  + bfa_pkg::SUMW'(lft_q.size);
  assign rsum     = bfa_pkg::SUMW'(bs) + bfa_pkg::SUMW'(bfa_pkg::HDR) + bfa_pkg::SUMW'(blen_q);
  assign left     = hl_q && (lsum == bfa_pkg::SUMW'(bs));
  assign right    = hr_q && (rsum == bfa_pkg::SUMW'(rgt_q.start));
  assign full     = fcnt_ext >= bfa_pkg::CNTW'(bfa_pkg::MAX_FREE_SEGS);
  assign nid      = ((next_id_q + 16'd1) == '0) ? 16'd1 : (next_id_q + 16'd1);

  logic done_tab, done_fscan, done_pscan, done_shup;
  assign done_tab   = !rv_q && (cnt_q >= fcnt_ext);
  assign done_fscan = !rv_q && (found_q || (cnt_q >= bfa_pkg::CNTW'(bfa_pkg::MAX_ALLOCS)));
  assign done_pscan = !rv_q && (found_q || (cnt_q >= fcnt_ext));
  assign done_shup  = !rv_q && (cnt_q <= pos_q);

  always_comb begin
    sts_o       = '0;
    sts_o.alloc = !action_i;
    sts_o.early = !action_i && ((request_size_i == '0) || !free_any);
    sts_o.done  = ((cmd_i.ascan || cmd_i.shdn) && done_tab) || (cmd_i.fscan && done_fscan)
               || (cmd_i.pscan && done_pscan) || (cmd_i.shup && done_shup);
    sts_o.found = found_q;
    sts_o.whole = whole;
    sts_o.both  = left && right;
    sts_o.one   = left || right;
    sts_o.full  = full;
  end

  always_comb begin
    fcount_d = fcount_q; next_id_d = next_id_q; valid_d = valid_q;
    cnt_d = cnt_q; rix_d = cnt_q; rv_d = 1'b0; found_d = found_q;
    hl_d = hl_q; hr_d = hr_q;
    req_d = req_q; id_d = id_q; best_d = best_q; bsize_d = bsize_q; bstart_d = bstart_q;
    slot_d = slot_q; bdat_d = bdat_q; blen_d = blen_q; pos_d = pos_q;
    lft_d = lft_q; rgt_d = rgt_q;
    rst_d = rst_q; roff_d = roff_q; rid_d = rid_q;
    fw_we = 1'b0; fw_addr = rix_q[bfa_pkg::FIDXW-1:0]; fw_data = fr_rdata;
    fr_addr = cnt_q[bfa_pkg::FIDXW-1:0];
    ar_addr = cnt_q[bfa_pkg::AIDXW-1:0];
    aw_we = 1'b0; aw_data = '0;

    if (cmd_i.init) begin
      fw_we   = 1'b1;
      fw_addr = '0;
      fw_data = {bfa_pkg::OFFW'(0), bfa_pkg::INIT_SIZE};
    end

    if (cmd_i.load) begin
      req_d   = request_size_i;
      id_d    = block_id_i;
      slot_d  = free_idx;
      cnt_d   = '0;
      found_d = 1'b0;
      roff_d  = '0;
      rid_d   = '0;
      rst_d   = (request_size_i == '0) ? bfa_pkg::ST_BADSIZE : bfa_pkg::ST_NOMEM;
    end

    // best-fit scan over the free table
    if (cmd_i.ascan) begin
      if (cnt_q < fcnt_ext) begin
        cnt_d = cnt_inc;
        rv_d  = 1'b1;
      end
      if (rv_q && (bfa_pkg::CMPW'(fr_seg.size) >= req_c)
          && (!found_q || (fr_seg.size < bsize_q))) begin
        found_d  = 1'b1;
        best_d   = rix_q;
        bsize_d  = fr_seg.size;
        bstart_d = fr_seg.start;
      end
    end

    if (cmd_i.aupd) begin
      if (found_q) begin
        if (whole) begin
          blen_d = bsize_q;
          rst_d  = bfa_pkg::ST_WHOLE;
          cnt_d  = best_q + bfa_pkg::CNTW'(1);
        end else begin
          blen_d  = bfa_pkg::OFFW'(req_q);
          rst_d   = bfa_pkg::ST_SPLIT;
          fw_we   = 1'b1;
          fw_addr = best_q[bfa_pkg::FIDXW-1:0];
          fw_data = {dat_a + bfa_pkg::OFFW'(req_q),
                     bsize_q - bfa_pkg::OFFW'(req_q) - bfa_pkg::HDR};
        end
        aw_we           = 1'b1;
        aw_data         = {next_id_q, dat_a,
                           whole ? bsize_q : bfa_pkg::OFFW'(req_q)};
        valid_d[slot_q] = 1'b1;
        next_id_d       = nid;
        roff_d          = dat_a;
        rid_d           = next_id_q;
      end else begin
        rst_d = bfa_pkg::ST_NOMEM;
      end
    end

    // id lookup over the allocation table
    if (cmd_i.fscan) begin
      if (!found_q && (cnt_q < bfa_pkg::CNTW'(bfa_pkg::MAX_ALLOCS))) begin
        cnt_d = cnt_inc;
        rv_d  = 1'b1;
      end
      if (rv_q && !found_q && valid_q[rix_q[bfa_pkg::AIDXW-1:0]]
          && (ar_rec.ident == id_q)) begin
        found_d = 1'b1;
        slot_d  = rix_q[bfa_pkg::AIDXW-1:0];
        bdat_d  = ar_rec.dat;
        blen_d  = ar_rec.len;
      end
      if (done_fscan) begin
        cnt_d   = '0;
        found_d = 1'b0;
        pos_d   = '0;
        hl_d    = 1'b0;
        hr_d    = 1'b0;
        rst_d   = bfa_pkg::ST_UNKNOWN;
      end
    end

    // locate insert position in the address-ordered free table
    if (cmd_i.pscan) begin
      if (!found_q && (cnt_q < fcnt_ext)) begin
        cnt_d = cnt_inc;
        rv_d  = 1'b1;
      end
      if (rv_q && !found_q) begin
        if (fr_seg.start < bs) begin
          pos_d = rix_inc;
          lft_d = fr_seg;
          hl_d  = 1'b1;
        end else begin
          found_d = 1'b1;
          rgt_d   = fr_seg;
          hr_d    = 1'b1;
        end
      end
    end

    if (cmd_i.fupd) begin
      rst_d  = bfa_pkg::ST_FREED;
      roff_d = bdat_q;
      rid_d  = id_q;
      if (left && right) begin
        fw_we   = 1'b1;
        fw_addr = pos_dec[bfa_pkg::FIDXW-1:0];
        fw_data = {lft_q.start, lft_q.size + bfa_pkg::HDR + blen_q + bfa_pkg::HDR + rgt_q.size};
        cnt_d   = pos_inc;
      end else if (left) begin
        fw_we   = 1'b1;
        fw_addr = pos_dec[bfa_pkg::FIDXW-1:0];
        fw_data = {lft_q.start, lft_q.size + bfa_pkg::HDR + blen_q};
      end else if (right) begin
        fw_we   = 1'b1;
        fw_addr = pos_q[bfa_pkg::FIDXW-1:0];
        fw_data = {bs, rgt_q.size + bfa_pkg::HDR + blen_q};
      end else if (full) begin
        rst_d  = bfa_pkg::ST_NOMEM;
        roff_d = '0;
        rid_d  = '0;
      end else begin
        cnt_d = fcnt_ext;
      end
      if (left || right || !full) begin
        valid_d[slot_q] = 1'b0;
      end
    end

    // close the gap: move entries one place toward the front
    if (cmd_i.shdn) begin
      if (cnt_q < fcnt_ext) begin
        cnt_d = cnt_inc;
        rv_d  = 1'b1;
      end
      if (rv_q) begin
        fw_we   = 1'b1;
        fw_addr = rix_dec[bfa_pkg::FIDXW-1:0];
      end
      if (done_tab) begin
        fcount_d = fcount_q - bfa_pkg::FCW'(1);
      end
    end

    // open a gap: move entries one place toward the back, then insert
    if (cmd_i.shup) begin
      fr_addr = cnt_dec[bfa_pkg::FIDXW-1:0];
      if (cnt_q > pos_q) begin
        cnt_d = cnt_dec;
        rix_d = cnt_dec;
        rv_d  = 1'b1;
      end
      if (rv_q) begin
        fw_we   = 1'b1;
        fw_addr = rix_inc[bfa_pkg::FIDXW-1:0];
      end
      if (done_shup) begin
        fw_we    = 1'b1;
        fw_addr  = pos_q[bfa_pkg::FIDXW-1:0];
        fw_data  = {bs, blen_q};
        fcount_d = fcount_q + bfa_pkg::FCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q  <= bfa_pkg::FCW'(1);
      next_id_q <= 16'd1;
      valid_q   <= '0;
      cnt_q     <= '0;
      rix_q     <= '0;
      rv_q      <= 1'b0;
      found_q   <= 1'b0;
      hl_q      <= 1'b0;
      hr_q      <= 1'b0;
    end else begin
      fcount_q  <= fcount_d;
      next_id_q <= next_id_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      rix_q     <= rix_d;
      rv_q      <= rv_d;
      found_q   <= found_d;
      hl_q      <= hl_d;
      hr_q      <= hr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    best_q   <= best_d;
    bsize_q  <= bsize_d;
    bstart_q <= bstart_d;
    slot_q   <= slot_d;
    bdat_q   <= bdat_d;
    blen_q   <= blen_d;
    pos_q    <= pos_d;
    lft_q    <= lft_d;
    rgt_q    <= rgt_d;
    rst_q    <= rst_d;
    roff_q   <= roff_d;
    rid_q    <= rid_d;
  end

  assign status_o      = rst_q;
  assign data_offset_o = bfa_pkg::DOFFW'(roff_q);
  assign assigned_id_o = rid_q;
  assign done_o        = cmd_i.fin;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fcnt_ext <= bfa_pkg::CNTW'(bfa_pkg::MAX_FREE_SEGS))
    else $error("free segment count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fw_we |-> (bfa_pkg::CNTW'(fw_addr) <= fcnt_ext))
    else $error("free table written beyond its fill level");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

### sv/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator: controller plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp (and bfa_ram through bfa_dp).
//
// Request/result behavior: a request is taken when start is high and
// busy is low; exactly one result follows, shown for a single cycle with
// done_o high, and it cannot be held off by the receiver. One request is
// worked at a time. After reset the block is busy for one cycle while it
// seeds the free table with the whole arena. A zero-size allocate, or one
// made while the allocation table is full, gives its result without a
// scan; an allocate scans the free table for the best fit, and the table
// closes up when a segment is taken whole; a free looks up the id in the
// allocation table, searches the free table by address, merges with an
// adjacent neighbour, and shifts the table to open or close an entry where
// needed. Each table is read one entry per cycle.
module best_fit_heap_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [bfa_pkg::REQW-1:0]      request_size_i,
  input  logic [bfa_pkg::IDW-1:0]       block_id_i,
  output logic                          done_o,
  output logic [bfa_pkg::STW-1:0]       status_o,
  output logic [bfa_pkg::DOFFW-1:0]     data_offset_o,
  output logic [bfa_pkg::IDW-1:0]       assigned_id_o
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  // sequence the request
  bfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // hold the tables and compute the result
  bfa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .request_size_i(request_size_i),
    .block_id_i    (block_id_i),
    .status_o      (status_o),
    .data_offset_o (data_offset_o),
    .assigned_id_o (assigned_id_o),
    .done_o        (done_o)
  );

endmodule
